@@ design/ihex_pkg.sv @@
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int MAX_LINE_BYTES = 32;
    localparam int LB_AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;

    localparam logic [8:0] LINE_MIN_LEN = 9'd11;
    localparam logic [8:0] IDX_SAT      = 9'd511;
    localparam logic [7:0] CHAR_NL      = 8'd10;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;

    localparam logic [7:0] REC_DATA = 8'd0;
    localparam logic [7:0] REC_EOF  = 8'd1;
    localparam logic [7:0] REC_ELA  = 8'd4;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_LINE_OK  = 2'd1;
    localparam logic [1:0] KIND_FILE_OK  = 2'd2;
    localparam logic [1:0] KIND_FILE_BAD = 2'd3;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_SHORT    = 4'd1;
    localparam logic [3:0] ERR_NO_COLON = 4'd2;
    localparam logic [3:0] ERR_COUNT    = 4'd3;
    localparam logic [3:0] ERR_CHECKSUM = 4'd4;
    localparam logic [3:0] ERR_TYPE     = 4'd5;
    localparam logic [3:0] ERR_NO_EOF   = 4'd6;
    localparam logic [3:0] ERR_DIGIT    = 4'd7;
    localparam logic [3:0] ERR_TOO_LONG = 4'd8;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } char_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] byte_address;
        logic [7:0]  byte_value;
        logic [3:0]  error_code;
        logic        run_last;
    } res_item_t;

    typedef enum logic [6:0] {
        S_RUN  = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_RD   = 7'b0000100,
        S_BYTE = 7'b0001000,
        S_REJ  = 7'b0010000,
        S_LINE = 7'b0100000,
        S_FILE = 7'b1000000
    } state_t;

endpackage

@@ design/ihex_ram.sv @@
`timescale 1ns / 1ps

module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/intel_hex_record_parser_unit.sv @@
`timescale 1ns / 1ps
// first result: after a line's newline or final item is accepted, the line passes S_EVAL; then
// S_REJ or S_LINE registers its first result, or S_RD then S_BYTE when the line carries data bytes
// input: one character per cycle inside a line; a passing line then holds input off through
// S_EVAL, an S_RD ram read and an S_BYTE emit per data byte, S_LINE, and S_FILE at end of file,
// and longer when the output stalls
// reset: asynchronous, active low; clears parse and file state, line buffer ram is not cleared

module intel_hex_record_parser_unit
    import ihex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_item_t char_item,
    output logic       res_valid,
    input  logic       res_ready,
    output res_item_t  res_item
);

    state_t state_reg, state_next;

    logic [8:0]  char_index_reg, char_index_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  last_byte_reg, last_byte_next;
    logic [7:0]  byte0_reg, byte0_next;
    logic [7:0]  byte1_reg, byte1_next;
    logic [15:0] upper_reg, upper_next;
    logic        failed_reg, failed_next;
    logic        colon_reg, colon_next;
    logic        hi_bad_reg, hi_bad_next;
    logic        bad_digit_reg, bad_digit_next;
    logic        too_long_reg, too_long_next;
    logic        fin_reg, fin_next;
    logic [3:0]  err_reg, err_next;
    logic [LB_AW-1:0] drain_idx_reg, drain_idx_next;

    logic      res_valid_reg, res_valid_next;
    res_item_t res_item_reg, res_item_next;

    logic             ram_wr_en;
    logic [LB_AW-1:0] ram_wr_addr;
    logic             ram_rd_en;
    logic [7:0]       ram_rd_data;

    logic        accept;
    logic        slot_free;
    logic [4:0]  hex_d;
    logic [3:0]  nib;
    logic [7:0]  pair_val;
    logic [7:0]  pair_idx;
    logic [7:0]  buf_idx;
    logic [8:0]  tmp9;
    logic [3:0]  line_err;
    logic [7:0]  idx_plus;
    logic        drain_last;
    logic        clear_line;
    logic        clear_file;

    // bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    assign char_ready = (state_reg == S_RUN);
    assign accept     = char_valid && char_ready;
    assign slot_free  = !res_valid_reg || res_ready;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;

    assign hex_d    = hex_val(char_item.char_code);
    assign nib      = hex_d[4] ? hex_d[3:0] : 4'd0;
    assign pair_val = {nibble_reg, nib};
    assign tmp9     = (char_index_reg - 9'd2) >> 1;
    assign pair_idx = tmp9[7:0];
    assign buf_idx  = pair_idx - 8'd5;

    // ram is only written while characters stream and only read while draining
    assign ram_wr_en = accept && (char_item.char_code != CHAR_NL)
        && (char_index_reg != IDX_SAT) && (char_index_reg != 9'd0)
        && !char_index_reg[0] && (pair_idx >= 8'd5)
        && (buf_idx < 8'(MAX_LINE_BYTES));
    assign ram_wr_addr = buf_idx[LB_AW-1:0];
    assign ram_rd_en   = (state_reg == S_RD);

    ihex_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (last_byte_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (drain_idx_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        line_err = ERR_NONE;
        if (char_index_reg < LINE_MIN_LEN)
        begin
            line_err = ERR_SHORT;
        end
        else if (!colon_reg)
        begin
            line_err = ERR_NO_COLON;
        end
        else if (bad_digit_reg)
        begin
            line_err = ERR_DIGIT;
        end
        else if (too_long_reg)
        begin
            line_err = ERR_TOO_LONG;
        end
        else if ({1'b0, count_reg} != ((char_index_reg - LINE_MIN_LEN) >> 1))
        begin
            line_err = ERR_COUNT;
        end
        else if (sum_reg != 8'd0)
        begin
            line_err = ERR_CHECKSUM;
        end
        else if (type_reg > REC_EOF && !(type_reg == REC_ELA && count_reg == 8'd2))
        begin
            line_err = ERR_TYPE;
        end
    end

    assign idx_plus   = 8'(drain_idx_reg) + 8'd1;
    assign drain_last = (idx_plus == count_reg) || (idx_plus == 8'(MAX_LINE_BYTES));

    always_comb
    begin
        state_next      = state_reg;
        char_index_next = char_index_reg;
        nibble_next     = nibble_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        offset_next     = offset_reg;
        type_next       = type_reg;
        last_byte_next  = last_byte_reg;
        byte0_next      = byte0_reg;
        byte1_next      = byte1_reg;
        upper_next      = upper_reg;
        failed_next     = failed_reg;
        colon_next      = colon_reg;
        hi_bad_next     = hi_bad_reg;
        bad_digit_next  = bad_digit_reg;
        too_long_next   = too_long_reg;
        fin_next        = fin_reg;
        err_next        = err_reg;
        drain_idx_next  = drain_idx_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_item_next   = res_item_reg;
        clear_line      = 1'b0;
        clear_file      = 1'b0;

        unique case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    if (char_item.char_code != CHAR_NL && char_index_reg != IDX_SAT)
                    begin
                        char_index_next = char_index_reg + 9'd1;
                        if (char_index_reg == 9'd0)
                        begin
                            colon_next = (char_item.char_code == CHAR_COLON);
                        end
                        else if (char_index_reg[0])
                        begin
                            nibble_next = nib;
                            hi_bad_next = !hex_d[4];
                        end
                        else
                        begin
                            if (hi_bad_reg || !hex_d[4])
                            begin
                                bad_digit_next = 1'b1;
                            end
                            sum_next = sum_reg + pair_val;
                            case (pair_idx)
                                8'd0: count_next = pair_val;
                                8'd1: offset_next = {pair_val, offset_reg[7:0]};
                                8'd2: offset_next = {offset_reg[15:8], pair_val};
                                8'd3: type_next = pair_val;
                                default:
                                begin
                                    if (pair_idx >= 8'd5)
                                    begin
                                        if (buf_idx >= 8'(MAX_LINE_BYTES))
                                        begin
                                            too_long_next = 1'b1;
                                        end
                                        else if (buf_idx == 8'd0)
                                        begin
                                            byte0_next = last_byte_reg;
                                        end
                                        else if (buf_idx == 8'd1)
                                        begin
                                            byte1_next = last_byte_reg;
                                        end
                                    end
                                    last_byte_next = pair_val;
                                end
                            endcase
                        end
                    end
                    if (char_item.char_code == CHAR_NL || char_item.final_char)
                    begin
                        if (failed_reg)
                        begin
                            // a failed file stays silent until its last character
                            clear_line = 1'b1;
                            clear_file = char_item.final_char;
                        end
                        else
                        begin
                            fin_next   = char_item.final_char;
                            state_next = S_EVAL;
                        end
                    end
                end
            end
            S_EVAL:
            begin
                drain_idx_next = '0;
                if (line_err != ERR_NONE)
                begin
                    err_next   = line_err;
                    state_next = S_REJ;
                end
                else if (fin_reg && type_reg != REC_EOF)
                begin
                    err_next   = ERR_NO_EOF;
                    state_next = S_REJ;
                end
                else
                begin
                    if (type_reg == REC_ELA)
                    begin
                        upper_next = {byte0_reg, byte1_reg};
                    end
                    if (type_reg == REC_DATA && count_reg != 8'd0)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_LINE;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_BYTE;
            end
            S_BYTE:
            begin
                if (slot_free)
                begin
                    res_valid_next             = 1'b1;
                    res_item_next.kind         = KIND_DATA;
                    res_item_next.byte_address = {upper_reg, offset_reg} + 32'(drain_idx_reg);
                    res_item_next.byte_value   = ram_rd_data;
                    res_item_next.error_code   = ERR_NONE;
                    res_item_next.run_last     = 1'b0;
                    if (drain_last)
                    begin
                        state_next = S_LINE;
                    end
                    else
                    begin
                        drain_idx_next = drain_idx_reg + LB_AW'(1);
                        state_next     = S_RD;
                    end
                end
            end
            S_REJ:
            begin
                if (slot_free)
                begin
                    res_valid_next             = 1'b1;
                    res_item_next.kind         = KIND_FILE_BAD;
                    res_item_next.byte_address = 32'd0;
                    res_item_next.byte_value   = 8'd0;
                    res_item_next.error_code   = err_reg;
                    res_item_next.run_last     = 1'b1;
                    failed_next                = 1'b1;
                    clear_line                 = 1'b1;
                    clear_file                 = fin_reg;
                    state_next                 = S_RUN;
                end
            end
            S_LINE:
            begin
                if (slot_free)
                begin
                    res_valid_next             = 1'b1;
                    res_item_next.kind         = KIND_LINE_OK;
                    res_item_next.byte_address = 32'd0;
                    res_item_next.byte_value   = 8'd0;
                    res_item_next.error_code   = ERR_NONE;
                    res_item_next.run_last     = !fin_reg;
                    if (fin_reg)
                    begin
                        state_next = S_FILE;
                    end
                    else
                    begin
                        clear_line = 1'b1;
                        state_next = S_RUN;
                    end
                end
            end
            S_FILE:
            begin
                if (slot_free)
                begin
                    res_valid_next             = 1'b1;
                    res_item_next.kind         = KIND_FILE_OK;
                    res_item_next.byte_address = 32'd0;
                    res_item_next.byte_value   = 8'd0;
                    res_item_next.error_code   = ERR_NONE;
                    res_item_next.run_last     = 1'b1;
                    clear_line                 = 1'b1;
                    clear_file                 = 1'b1;
                    state_next                 = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase

        if (clear_line)
        begin
            char_index_next = 9'd0;
            nibble_next     = 4'd0;
            sum_next        = 8'd0;
            count_next      = 8'd0;
            offset_next     = 16'd0;
            type_next       = 8'd0;
            last_byte_next  = 8'd0;
            colon_next      = 1'b0;
            hi_bad_next     = 1'b0;
            bad_digit_next  = 1'b0;
            too_long_next   = 1'b0;
            fin_next        = 1'b0;
        end
        if (clear_file)
        begin
            upper_next  = 16'd0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RUN;
            char_index_reg <= '0;
            nibble_reg     <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            offset_reg     <= '0;
            type_reg       <= '0;
            last_byte_reg  <= '0;
            byte0_reg      <= '0;
            byte1_reg      <= '0;
            upper_reg      <= '0;
            failed_reg     <= 1'b0;
            colon_reg      <= 1'b0;
            hi_bad_reg     <= 1'b0;
            bad_digit_reg  <= 1'b0;
            too_long_reg   <= 1'b0;
            fin_reg        <= 1'b0;
            err_reg        <= '0;
            drain_idx_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_index_reg <= char_index_next;
            nibble_reg     <= nibble_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            offset_reg     <= offset_next;
            type_reg       <= type_next;
            last_byte_reg  <= last_byte_next;
            byte0_reg      <= byte0_next;
            byte1_reg      <= byte1_next;
            upper_reg      <= upper_next;
            failed_reg     <= failed_next;
            colon_reg      <= colon_next;
            hi_bad_reg     <= hi_bad_next;
            bad_digit_reg  <= bad_digit_next;
            too_long_reg   <= too_long_next;
            fin_reg        <= fin_next;
            err_reg        <= err_next;
            drain_idx_reg  <= drain_idx_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("parser state not one-hot");

    a_reject_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.kind == KIND_FILE_BAD |-> res_item.error_code != ERR_NONE)
        else $error("file rejected without an error code");

    a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.kind == KIND_DATA |-> !res_item.run_last)
        else $error("data byte marked as last result of an item");

    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BYTE |-> 8'(drain_idx_reg) < count_reg)
        else $error("drain index past the record byte count");

endmodule
